// ===== hw/rtl/sqss_pkg.sv =====
// ----------------------------------------------------------------------------
// sqss_pkg
// Shared types and constants for the shift queue with search statistics.
// ----------------------------------------------------------------------------
package sqss_pkg;

  localparam int unsigned Depth    = 8;
  localparam int unsigned WordBits = 32;
  localparam int unsigned IdxBits  = $clog2(Depth);
  localparam int unsigned CntBits  = $clog2(Depth + 1);
  localparam int unsigned SumBits  = WordBits + CntBits;
  localparam int unsigned DivSteps = SumBits;
  localparam int unsigned DivCntBits = $clog2(DivSteps + 1);

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_SRCH  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request and apply command
    logic stat_clr;  // start a statistics pass
    logic stat_step; // fold one entry into statistics
    logic div_init;  // set up the divider
    logic div_step;  // one restoring divide step
    logic out_load;  // move result into output register
  } sqss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stat_last; // current entry is the last held one
    logic empty;     // no entries held
    logic div_last;  // final divide step
  } sqss_sts_t;

endpackage

// ===== hw/rtl/sqss_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqss_ctrl
// Sequencer: command, statistics pass, divide, then output.
// ----------------------------------------------------------------------------
module sqss_ctrl import sqss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_busy_i,
  input  sqss_sts_t sts_i,
  output sqss_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_STAT = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.stat_clr = 1'b1;
        state_d = sts_i.empty ? S_OUT : S_STAT;
      end
      S_STAT: begin
        cmd_o.stat_step = 1'b1;
        if (sts_i.stat_last) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/sqss_dp.sv =====
// ----------------------------------------------------------------------------
// sqss_dp
// Shift array, search, serial statistics and restoring divider.
// ----------------------------------------------------------------------------
module sqss_dp import sqss_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sqss_cmd_t                  cmd_i,
  output sqss_sts_t                  sts_o,
  input  logic [1:0]                 op_i,
  input  logic signed [31:0]         value_i,
  output logic [1:0]                 status_o,
  output logic signed [31:0]         popped_o,
  output logic [7:0]                 mask_o,
  output logic                       found_o,
  output logic [3:0]                 count_o,
  output logic signed [34:0]         sum_o,
  output logic signed [31:0]         min_o,
  output logic signed [31:0]         max_o,
  output logic signed [31:0]         mean_o
);

  logic signed [WordBits-1:0] ent_q [Depth];
  logic [CntBits-1:0]         cnt_q;
  logic signed [WordBits-1:0] key;
  logic [Depth-1:0]           hit;
  logic [1:0]                 status_q;
  logic signed [WordBits-1:0] pop_q;
  logic [Depth-1:0]           hit_q;
  logic [IdxBits-1:0]         idx_q;
  logic signed [SumBits-1:0]  sum_q;
  logic signed [WordBits-1:0] lo_q, hi_q, cur;
  logic [SumBits-1:0]         quo_q, rem_q, mag;
  logic [SumBits:0]           trial;
  logic                       neg_q;
  logic [DivCntBits-1:0]      dcnt_q;
  logic signed [SumBits-1:0]  mean_full;

  assign key = value_i[WordBits-1:0];

  // search compare over held entries
  always_comb begin
    for (int i = 0; i < Depth; i++)
      hit[i] = (ent_q[i] == key) && (CntBits'(i) < cnt_q);
  end

  // entry array and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.load) begin
      case (op_i)
        OP_ENQ:   if (cnt_q != CntBits'(Depth)) cnt_q <= cnt_q + 1'b1;
        OP_DEQ:   if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        OP_CLEAR: cnt_q <= '0;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= ST_OK;
      pop_q    <= '0;
      hit_q    <= '0;
      case (op_i)
        OP_ENQ: begin
          if (cnt_q == CntBits'(Depth)) status_q <= ST_FULL;
          else ent_q[cnt_q[IdxBits-1:0]] <= key;
        end
        OP_DEQ: begin
          if (cnt_q == '0) status_q <= ST_EMPTY;
          else begin
            pop_q <= ent_q[0];
            for (int i = 0; i < Depth - 1; i++) ent_q[i] <= ent_q[i+1];
          end
        end
        OP_SRCH: hit_q <= hit;
        default: ;
      endcase
    end
  end

  // serial statistics over held entries
  assign cur = ent_q[idx_q];
  always_ff @(posedge clk_i) begin
    if (cmd_i.stat_clr) begin
      idx_q <= '0;
      sum_q <= '0;
      lo_q  <= '0;
      hi_q  <= '0;
    end else if (cmd_i.stat_step) begin
      idx_q <= idx_q + 1'b1;
      sum_q <= sum_q + SumBits'(cur);
      if (idx_q == '0 || cur < lo_q) lo_q <= cur;
      if (idx_q == '0 || cur > hi_q) hi_q <= cur;
    end
  end

  assign sts_o.stat_last = ({1'b0, idx_q} + 1'b1) == (IdxBits+1)'(cnt_q);
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.div_last  = (dcnt_q == DivCntBits'(1));

  // restoring divide of |sum| by count, one bit a step
  logic signed [SumBits-1:0] nsum;
  assign nsum  = sum_q + SumBits'(cur);
  assign mag   = nsum[SumBits-1] ? SumBits'(-nsum) : SumBits'(nsum);
  assign trial = {rem_q, quo_q[SumBits-1]} - (SumBits+1)'(cnt_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.stat_clr) begin
      quo_q <= '0;
      neg_q <= 1'b0;
    end else if (cmd_i.div_init) begin
      quo_q  <= mag;
      rem_q  <= '0;
      neg_q  <= nsum[SumBits-1];
      dcnt_q <= DivCntBits'(DivSteps);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (!trial[SumBits]) begin
        rem_q <= trial[SumBits-1:0];
        quo_q <= {quo_q[SumBits-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[SumBits-2:0], quo_q[SumBits-1]};
        quo_q <= {quo_q[SumBits-2:0], 1'b0};
      end
    end
  end

  assign mean_full = neg_q ? -$signed(quo_q) : $signed(quo_q);

  // result fields
  always_comb begin
    mask_o = '0;
    for (int i = 0; i < Depth && i < 8; i++) mask_o[i] = hit_q[i];
  end
  assign status_o = status_q;
  assign popped_o = 32'(pop_q);
  assign found_o  = |hit_q;
  assign count_o  = 4'(cnt_q);
  assign sum_o    = 35'(sum_q);
  assign min_o    = 32'(lo_q);
  assign max_o    = 32'(hi_q);
  assign mean_o   = 32'(mean_full);

endmodule

// ===== hw/rtl/shift_queue_with_search_stats.sv =====
// ----------------------------------------------------------------------------
// shift_queue_with_search_stats
// Shift-register queue with enqueue, dequeue, search, clear and statistics.
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_axis   in   tdata = op[1:0], value[33:2]
// m_axis   out  tdata = status, popped_value, match_mask, match_found,
//               item_count, total_sum, smallest, largest, mean
// One request passes through a load state, a setup state, a statistics pass
// over the held entries, 36 divide steps and an output state that waits
// while the output register is held; an empty queue skips the pass and
// divide. The serial divider sets the pace. New requests wait for idle.
// Reset empties the queue; entry storage is not cleared.
// A held result waits in the output register while m_axis_tready is low.
// ----------------------------------------------------------------------------
module shift_queue_with_search_stats import sqss_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // op[1:0], value[33:2], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [183:0] m_axis_tdata   // status, popped_value, match_mask,
                                      // match_found, item_count, total_sum,
                                      // smallest, largest, mean, zero pad
);

  sqss_cmd_t cmd;
  sqss_sts_t sts;
  logic [1:0]         op_q;
  logic signed [31:0] value_q;
  logic [1:0]         status;
  logic signed [31:0] popped, mn, mx, mean;
  logic [7:0]         mask;
  logic               found;
  logic [3:0]         count;
  logic signed [34:0] sum;
  logic               ovalid_q;
  logic [177:0]       odata_q;

  assign op_q    = s_axis_tdata[1:0];
  assign value_q = s_axis_tdata[33:2];

  sqss_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (ovalid_q && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sqss_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .sts_o (sts),
    .op_i (op_q), .value_i (value_q),
    .status_o (status), .popped_o (popped), .mask_o (mask), .found_o (found),
    .count_o (count), .sum_o (sum), .min_o (mn), .max_o (mx), .mean_o (mean)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd.out_load) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load)
      odata_q <= {mean, mx, mn, sum, count, found, mask, popped, status};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'b000000, odata_q};

endmodule

// ===== tb/shift_queue_with_search_stats_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shift_queue_with_search_stats_test
// Drives queue commands (enqueue, dequeue, search, clear) in random bursts,
// predicts each response with a local model of the shift queue and its
// statistics, and compares every response field by field in order.
// ----------------------------------------------------------------------------
module shift_queue_with_search_stats_test;
  import sqss_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  // lowest field last, so status sits in the low bits
  typedef struct packed {
    logic [31:0] avg;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [34:0] sum;
    logic [3:0]  count;
    logic        found;
    logic [7:0]  mask;
    logic [31:0] popped;
    logic [1:0]  status;
  } resp_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [183:0] m_axis_tdata;

  shift_queue_with_search_stats uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // model state
  logic signed [31:0] q_words [Depth];
  int unsigned        q_fill;

  logic [39:0] pending_reqs [$];
  resp_t       expected_resps [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_phase;
  bit          stim_done;
  bit          hold_off;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // apply one command to the queue model and build its response
  function automatic resp_t predict_queue(op_e op, logic signed [31:0] val);
    resp_t r;
    logic signed [34:0] acc;
    logic signed [31:0] mn, mx;
    r = '0;
    case (op)
      OP_ENQ: begin
        if (q_fill >= Depth) r.status = ST_FULL;
        else begin
          q_words[q_fill] = val;
          q_fill++;
        end
      end
      OP_DEQ: begin
        if (q_fill == 0) r.status = ST_EMPTY;
        else begin
          r.popped = q_words[0];
          for (int i = 0; i + 1 < q_fill; i++) q_words[i] = q_words[i+1];
          q_fill--;
        end
      end
      OP_SRCH: begin
        for (int i = 0; i < q_fill; i++)
          if (q_words[i] == val) begin
            r.found = 1'b1;
            if (i < 8) r.mask[i] = 1'b1;
          end
      end
      default: q_fill = 0;
    endcase
    acc = '0;
    mn = '0;
    mx = '0;
    for (int i = 0; i < q_fill; i++) begin
      acc += 35'(q_words[i]);
      if (i == 0 || q_words[i] < mn) mn = q_words[i];
      if (i == 0 || q_words[i] > mx) mx = q_words[i];
    end
    r.count = 4'(q_fill);
    r.sum = acc;
    r.lo = mn;
    r.hi = mx;
    if (q_fill != 0) r.avg = 32'(acc / $signed({1'b0, 35'(q_fill)}));
    return r;
  endfunction

  function automatic logic [31:0] pick_word(logic signed [31:0] known);
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return known;
      3: return 32'($urandom_range(0, 6)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(op_e op, logic [31:0] val);
    pending_reqs.push_back({6'd0, val, op});
  endtask

  // stimulus
  initial begin
    logic [31:0] recent;
    rst_ni = 1'b0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    recent = 32'd5;
    // directed: empty cases, extremes, fill past full, search, clear
    push_req(OP_DEQ, 32'hffff_ffff);
    push_req(OP_SRCH, 32'd0);
    push_req(OP_ENQ, 32'h8000_0000);
    push_req(OP_ENQ, 32'h7fff_ffff);
    push_req(OP_ENQ, 32'hffff_ffff);
    push_req(OP_ENQ, 32'h8000_0000);
    push_req(OP_ENQ, 32'h8000_0000);
    push_req(OP_ENQ, 32'h8000_0000);
    push_req(OP_ENQ, 32'h8000_0001);
    push_req(OP_ENQ, 32'h8000_0000);
    push_req(OP_ENQ, 32'd1);
    push_req(OP_SRCH, 32'h8000_0000);
    push_req(OP_SRCH, 32'h1234_5678);
    push_req(OP_DEQ, 32'd0);
    push_req(OP_SRCH, 32'hffff_ffff);
    push_req(OP_CLEAR, 32'hffff_ffff);
    push_req(OP_SRCH, 32'h8000_0000);
    push_req(OP_ENQ, 32'hffff_fffd);
    push_req(OP_ENQ, 32'd1);
    push_req(OP_DEQ, 32'd0);
    push_req(OP_DEQ, 32'd0);
    push_req(OP_DEQ, 32'd0);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // random commands, biased toward enqueue so the queue fills often
    for (int n = 0; n < 1530; n++) begin
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 45) begin
        recent = pick_word(recent);
        push_req(OP_ENQ, recent);
      end else if (k < 75) push_req(OP_DEQ, $urandom);
      else if (k < 95) push_req(OP_SRCH, pick_word(recent));
      else push_req(OP_CLEAR, $urandom);
      if (n == 700) begin
        // pause until every response has arrived
        wait (pending_reqs.size() == 0);
        hold_off = 1'b1;
        wait (expected_resps.size() == 0);
        hold_off = 1'b0;
      end
    end
    wait (pending_reqs.size() == 0 && expected_resps.size() == 0);
    stim_done = 1'b1;
  end

  // request driver with bursts and gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
      q_fill = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_resps.push_back(
          predict_queue(op_e'(s_axis_tdata[1:0]), s_axis_tdata[33:2]));
        void'(pending_reqs.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold current request
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0 && !hold_off) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_reqs[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 60);
        end else burst_left <= burst_left - 1;
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // response monitor and stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_phase <= 0;
      mismatches <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_resps.size() == 0) begin
          if (mismatches < 10) $display("unexpected response %h", m_axis_tdata);
          mismatches <= mismatches + 1;
        end else begin
          resp_t e;
          resp_t a;
          e = expected_resps.pop_front();
          a = m_axis_tdata[$bits(resp_t)-1:0];
          if (a.status != e.status || a.popped != e.popped || a.mask != e.mask ||
              a.found != e.found || a.count != e.count || a.sum != e.sum ||
              a.lo != e.lo || a.hi != e.hi || a.avg != e.avg) begin
            if (mismatches < 10)
              $display("mismatch: expected %h actual %h", e, a);
            mismatches <= mismatches + 1;
          end
        end
      end
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 500) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ((stall_phase % 37) > 20);
      endcase
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (stim_done) begin
        repeat (100) @(posedge clk_i);
        if (mismatches == 0 && expected_resps.size() == 0)
          $display("shift_queue_with_search_stats_test passed");
        else
          $display("shift_queue_with_search_stats_test failed");
        $finish;
      end else if (idle_cycles >= WatchLimit) begin
        $display("shift_queue_with_search_stats_test failed");
        $finish;
      end
    end
  end

endmodule
